// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks for duplicate_frame_filter under rtl/core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocking and reset qualifier, expects aclk and aresetn in scope
`define DUP_PROP(p) @(posedge aclk) disable iff (!aresetn) (p)

// plain check
`define DUP_ASSERT(lbl, p, msg) \
    lbl: assert property (`DUP_PROP(p)) else $error(msg);

// antecedent / consequent check, same cycle
`define DUP_ASSERT_IMP(lbl, a, c, msg) \
    lbl: assert property (`DUP_PROP((a) |-> (c))) else $error(msg);

`endif

// ----- rtl/core/dup_pkg.sv -----
// ----------------------------------------------------------------------------
// dup_pkg
// Types and constants of the duplicate frame filter.
// ----------------------------------------------------------------------------
package dup_pkg;

    localparam int ADDR_W  = 64;
    localparam int CTR_W   = 8;
    localparam int ENTRY_W = ADDR_W + CTR_W;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 8;

    typedef struct packed {
        logic [CTR_W-1:0]  ctr;
        logic [ADDR_W-1:0] addr;
    } entry_t;

    typedef struct packed {
        logic table_full;
        logic new_sender;
        logic is_retry;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_HIT    = 4'b0100,
        ST_MISS   = 4'b1000
    } state_t;

endpackage

// ----- rtl/core/dup_ram.sv -----
// ----------------------------------------------------------------------------
// dup_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module dup_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ----- rtl/core/duplicate_frame_filter.sv -----
// Search: a hit on entry i ends the search with entry i; a miss compares all n
// stored senders first, and an empty table goes straight to the miss step.
// Throughput: one item at a time, set by the linear search through the sender
// RAM at one entry per cycle; m_tready stalls in the result step hold it longer.
// Reset: synchronous, active low; clears the sender count and control state.
// RAM contents are not cleared; only entries below the count are compared.
// ----------------------------------------------------------------------------
// duplicate_frame_filter
// Retry detection on received frames by sender address and frame counter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module duplicate_frame_filter
    import dup_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [63:0] source_address, [71:64] frame_counter
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [0] is_retry, [1] new_sender, [2] table_full
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [CTR_W-1:0]   ctr_reg, ctr_next;
    logic               ctr_eq_reg, ctr_eq_next;
    logic               m_valid_reg, m_valid_next;
    result_t            res_reg, res_next;

    logic               s_beat;
    logic               out_free;
    logic               hit;
    logic               last;
    logic               full;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [IDX_W-1:0]   ram_raddr;
    entry_t             ram_wdata;
    entry_t             ram_rdata;
    logic [ENTRY_W-1:0] ram_rdata_raw;

    dup_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = entry_t'(ram_rdata_raw);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W - 3)'(0), res_reg};

    assign hit  = (ram_rdata.addr == addr_reg);
    assign last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign full = (count_reg == CNT_W'(ENTRIES));

    // entry i is read while idx_reg moves to i, data arrives with idx_reg == i
    always_comb begin
        ram_raddr = '0;
        if (state_reg == ST_SEARCH) begin
            ram_raddr = idx_reg + IDX_W'(1);
        end
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        addr_next    = addr_reg;
        ctr_next     = ctr_reg;
        ctr_eq_next  = ctr_eq_reg;
        m_valid_next = m_valid_reg && !m_tready;
        res_next     = res_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = '{ctr: ctr_reg, addr: addr_reg};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    addr_next = s_tdata[ADDR_W-1:0];
                    ctr_next  = s_tdata[ADDR_W +: CTR_W];
                    idx_next  = '0;
                    if (count_reg == '0) begin
                        state_next = ST_MISS;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    ctr_eq_next = (ram_rdata.ctr == ctr_reg);
                    state_next  = ST_HIT;
                end else if (last) begin
                    state_next = ST_MISS;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_HIT: begin
                if (out_free) begin
                    ram_we       = !ctr_eq_reg;
                    m_valid_next = 1'b1;
                    res_next     = '{table_full: 1'b0, new_sender: 1'b0,
                                     is_retry: ctr_eq_reg};
                    state_next   = ST_IDLE;
                end
            end
            ST_MISS: begin
                if (out_free) begin
                    ram_we       = !full;
                    ram_waddr    = count_reg[IDX_W-1:0];
                    m_valid_next = 1'b1;
                    res_next     = '{table_full: full, new_sender: 1'b1,
                                     is_retry: 1'b0};
                    if (!full) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        addr_reg   <= addr_next;
        ctr_reg    <= ctr_next;
        ctr_eq_reg <= ctr_eq_next;
        res_reg    <= res_next;
    end

    `DUP_ASSERT(a_count_bound, count_reg <= CNT_W'(ENTRIES), "sender count above capacity")
    `DUP_ASSERT_IMP(a_we_ctx, ram_we, (state_reg == ST_HIT || state_reg == ST_MISS) && out_free, "RAM write outside result step")
    `DUP_ASSERT_IMP(a_res_flags, m_valid_reg, !(res_reg.is_retry && res_reg.new_sender) && (!res_reg.table_full || res_reg.new_sender), "inconsistent result flags")
    `DUP_ASSERT_IMP(a_count_step, count_reg != $past(count_reg), m_valid_reg && res_reg.new_sender && !res_reg.table_full, "count moved without stored sender")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the duplicate frame filter. A scoreboard class keeps
// its own sender table, predicts retry / new / full flags for every input beat
// and compares them with each result beat in order. Directed beats fill the
// table and hit every flag combination, then random beats mix known senders,
// one-bit near misses and unknown addresses under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import dup_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_BEATS = 1626;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    class retry_scoreboard;
        logic [ADDR_W-1:0] sender_addr[TABLE_DEPTH];
        logic [CTR_W-1:0]  sender_ctr[TABLE_DEPTH];
        int unsigned       sender_count;
        result_t           flags_q[$];
        int                mismatches;
        int                results_seen;

        function new();
            sender_count = 0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void note_input(logic [ADDR_W-1:0] addr, logic [CTR_W-1:0] ctr);
            result_t r;
            bit      hit;
            r   = '0;
            hit = 0;
            for (int i = 0; i < sender_count; i++) begin
                if (!hit && sender_addr[i] == addr) begin
                    hit = 1;
                    if (sender_ctr[i] == ctr) r.is_retry = 1'b1;
                    else sender_ctr[i] = ctr;
                end
            end
            if (!hit) begin
                r.new_sender = 1'b1;
                if (sender_count >= TABLE_DEPTH) begin
                    r.table_full = 1'b1;
                end else begin
                    sender_addr[sender_count] = addr;
                    sender_ctr[sender_count]  = ctr;
                    sender_count++;
                end
            end
            flags_q.push_back(r);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data);
            result_t exp_flags;
            result_t got;
            got = data[2:0];
            results_seen++;
            if (flags_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb_top: result beat %0d with nothing pending, got %b",
                             results_seen, data);
                return;
            end
            exp_flags = flags_q.pop_front();
            if (got.is_retry !== exp_flags.is_retry ||
                got.new_sender !== exp_flags.new_sender ||
                got.table_full !== exp_flags.table_full ||
                data[M_DATA_W-1:3] !== '0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb_top: beat %0d expected retry/new/full %0b%0b%0b, got %b%b%b pad %b",
                             results_seen, exp_flags.is_retry, exp_flags.new_sender,
                             exp_flags.table_full, got.is_retry, got.new_sender,
                             got.table_full, data[M_DATA_W-1:3]);
            end
        endfunction

        function int pending();
            return flags_q.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    retry_scoreboard     sb;
    int                  sent;
    bit                  calm;
    int                  quiet_cycles;

    logic [ADDR_W-1:0]   known_addr[$];
    logic [CTR_W-1:0]    known_ctr[$];

    duplicate_frame_filter #(.ENTRIES(TABLE_DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // sampling at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (s_tvalid && s_tready) sb.note_input(s_tdata[ADDR_W-1:0],
                                                    s_tdata[S_DATA_W-1:ADDR_W]);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // result side: random backpressure, one long hold-off
    initial begin
        int  hold_left;
        bit  held;
        m_tready  = 1'b0;
        hold_left = 0;
        held      = 0;
        forever begin
            @(negedge aclk);
            if (!held && sent >= 400) begin
                held      = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 28);
            end
        end
    end

    function automatic bit is_known(logic [ADDR_W-1:0] addr);
        foreach (known_addr[i])
            if (known_addr[i] == addr) return 1;
        return 0;
    endfunction

    task automatic send_beat(input logic [ADDR_W-1:0] addr, input logic [CTR_W-1:0] ctr);
        int gap;
        int idx;
        gap = 0;
        if (!calm)
            while ($urandom_range(99) < 28) gap++;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {ctr, addr};
        do @(posedge aclk); while (!s_tready);
        sent++;
        // stimulus-side shadow of stored counters
        idx = -1;
        foreach (known_addr[i])
            if (known_addr[i] == addr) idx = i;
        if (idx >= 0) known_ctr[idx] = ctr;
        else if (known_addr.size() < TABLE_DEPTH) begin
            known_addr.push_back(addr);
            known_ctr.push_back(ctr);
        end
    endtask

    task automatic wait_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        logic [ADDR_W-1:0] addr;
        logic [CTR_W-1:0]  ctr;
        int                sel;
        int                k;
        int                failures;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        sent         = 0;
        calm         = 0;
        quiet_cycles = 0;
        sb           = new();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: new, retry, update at the field extremes
        send_beat('0, 8'h00);
        send_beat('0, 8'h00);
        send_beat('0, 8'hFF);
        send_beat('1, 8'hFF);
        send_beat('1, 8'hFF);
        send_beat('1, 8'h00);
        send_beat('0, 8'hFF);
        // fill the table
        while (known_addr.size() < TABLE_DEPTH) begin
            addr = {$urandom, $urandom};
            if (!is_known(addr)) send_beat(addr, CTR_W'($urandom));
        end
        // table full: unknown, a one-bit near miss and a retry of a stored sender
        do addr = {$urandom, $urandom}; while (is_known(addr));
        send_beat(addr, CTR_W'($urandom));
        send_beat({ADDR_W{1'b1}} ^ 64'h1, 8'hFF);
        send_beat(known_addr[TABLE_DEPTH-1], known_ctr[TABLE_DEPTH-1]);
        wait_results();

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            calm = (n >= 600 && n < 900);
            if (n == 1000) wait_results();
            sel = $urandom_range(99);
            k   = $urandom_range(TABLE_DEPTH - 1);
            if (sel < 70) begin
                addr = known_addr[k];
                ctr  = ($urandom_range(1) == 0) ? known_ctr[k] : CTR_W'($urandom);
            end else if (sel < 85) begin
                addr = known_addr[k] ^ (64'h1 << $urandom_range(ADDR_W - 1));
                ctr  = known_ctr[k];
            end else begin
                addr = {$urandom, $urandom};
                ctr  = CTR_W'($urandom);
            end
            send_beat(addr, ctr);
        end
        calm = 0;

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        failures = sb.mismatches + sb.pending();
        if (failures == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
